// ----- hw/rtl/lpvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpvs_pkg;

  localparam int PAGES_PER_TABLE = 64;
  localparam int NUM_TABLES      = 2;
  localparam int TOTAL_ENTRIES   = NUM_TABLES * PAGES_PER_TABLE;

  localparam int ENT_W  = (PAGES_PER_TABLE > 1) ? $clog2(PAGES_PER_TABLE) : 1;
  localparam int TAB_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int SLOT_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
  localparam int TIME_W = 31;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_PRESENT = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;

  // per-cycle control from the sequencer to the compare stage
  typedef struct packed {
    logic             start;
    logic             hit;
    logic [TAB_W-1:0] tab;
    logic [ENT_W-1:0] ent;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [TAB_W-1:0] tab;
    logic [ENT_W-1:0] ent;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpvs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lpvs_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpvs_scan
  import lpvs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scan_ctl_t         ctl,
  input  wire logic [TIME_W-1:0] rd_data,
  output      scan_res_t         res
);

  // stage aligned with the RAM read latency
  logic             hit_r;
  logic [TAB_W-1:0] tab_r;
  logic [ENT_W-1:0] ent_r;

  logic [TIME_W-1:0] best_r, best_nxt;
  scan_res_t         res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= ctl.hit;
    end
  end

  always_ff @(posedge clk) begin
    tab_r  <= ctl.tab;
    ent_r  <= ctl.ent;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    best_nxt = best_r;
    res_nxt  = res_r;
    if (ctl.start) begin
      best_nxt = TIME_MAX;
      res_nxt  = '0;
    end else if (hit_r && (rd_data < best_r)) begin
      // strict compare: the first entry scanned keeps a tie
      best_nxt      = rd_data;
      res_nxt.found = 1'b1;
      res_nxt.tab   = tab_r;
      res_nxt.ent   = ent_r;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lru_page_victim_selector_unit.sv -----
// LRU page victim selector.
// Input channel (in_valid/in_ready) takes one command per transfer:
//   write entry  - stores valid bit and last-use time of one page entry,
//   set present  - marks one page table present or absent,
//   find victim  - scans all entries and returns one result transfer.
// Write and present commands produce no result.
// A find reads the timestamp RAM once per entry, tables and entries in
// ascending order (scan state), then passes a drain state for the read
// pipeline and a done state that loads the result register. The next
// command can transfer once the block is back in idle. The single RAM
// read port is why the scan reads one entry at a time. in_ready is low during a find.
// The result (out_valid/out_ready) sits in an output register; a stalled
// receiver does not block further write/present commands, but a following
// find holds its result until the previous one has been taken.
// Entries whose timestamp is all ones are never chosen; with no candidate
// out_victim_found is 0 and table/entry read 0.
// Reset (rst_n low, synchronous) clears all valid bits, present flags and
// the output valid flag; timestamps are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_victim_selector_unit
  import lpvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic        in_table_sel,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic        in_valid_flag,
  input  wire logic [30:0] in_last_use_time,
  input  wire logic        in_present_flag,

  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_victim_found,
  output      logic        out_victim_table,
  output      logic [5:0]  out_victim_entry
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [TOTAL_ENTRIES-1:0] valid_r, valid_nxt;
  logic [NUM_TABLES-1:0]    present_r, present_nxt;
  logic [TAB_W-1:0]         scan_tab_r, scan_tab_nxt;
  logic [ENT_W-1:0]         scan_ent_r, scan_ent_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  logic       out_table_r, out_table_nxt;
  logic [5:0] out_entry_r, out_entry_nxt;

  logic              in_fire;
  logic              tab_ok, ent_ok;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic              ram_we;
  logic [TIME_W-1:0] ram_rdata;
  logic              scan_last;
  scan_ctl_t         ctl;
  scan_res_t         res;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign tab_ok  = (32'(in_table_sel) < 32'(NUM_TABLES));
  assign ent_ok  = (32'(in_entry_index) < 32'(PAGES_PER_TABLE));
  assign wr_slot = SLOT_W'(SLOT_W'(in_table_sel) * SLOT_W'(PAGES_PER_TABLE)
                   + SLOT_W'(in_entry_index));
  assign rd_slot = SLOT_W'(SLOT_W'(scan_tab_r) * SLOT_W'(PAGES_PER_TABLE)
                   + SLOT_W'(scan_ent_r));
  assign ram_we  = in_fire && (in_cmd == CMD_WRITE) && tab_ok && ent_ok;

  assign scan_last = (scan_tab_r == TAB_W'(NUM_TABLES - 1)) &&
                     (scan_ent_r == ENT_W'(PAGES_PER_TABLE - 1));

  lpvs_ram #(
    .WIDTH(TIME_W),
    .DEPTH(TOTAL_ENTRIES)
  ) u_time_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_slot),
    .wdata(in_last_use_time),
    .raddr(rd_slot),
    .rdata(ram_rdata)
  );

  always_comb begin
    ctl.start = in_fire && (in_cmd == CMD_FIND);
    ctl.hit   = (state_r == ST_SCAN) && valid_r[rd_slot] && present_r[scan_tab_r];
    ctl.tab   = scan_tab_r;
    ctl.ent   = scan_ent_r;
  end

  lpvs_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rd_data(ram_rdata),
    .res    (res)
  );

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    present_nxt   = present_r;
    scan_tab_nxt  = scan_tab_r;
    scan_ent_nxt  = scan_ent_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_table_nxt = out_table_r;
    out_entry_nxt = out_entry_r;

    if (ram_we) begin
      valid_nxt[wr_slot] = in_valid_flag;
    end
    if (in_fire && (in_cmd == CMD_PRESENT) && tab_ok) begin
      present_nxt[TAB_W'(in_table_sel)] = in_present_flag;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_cmd == CMD_FIND)) begin
          scan_tab_nxt = '0;
          scan_ent_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end else if (scan_ent_r == ENT_W'(PAGES_PER_TABLE - 1)) begin
          scan_ent_nxt = '0;
          scan_tab_nxt = scan_tab_r + TAB_W'(1);
        end else begin
          scan_ent_nxt = scan_ent_r + ENT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res.found;
          out_table_nxt = 1'(res.tab);
          out_entry_nxt = 6'(res.ent);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_tab_r  <= scan_tab_nxt;
    scan_ent_r  <= scan_ent_nxt;
    out_found_r <= out_found_nxt;
    out_table_r <= out_table_nxt;
    out_entry_r <= out_entry_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_victim_found = out_found_r;
  assign out_victim_table = out_table_r;
  assign out_victim_entry = out_entry_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lpvs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpvs_checker
  import lpvs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_victim_found,
  input wire logic        out_victim_table,
  input wire logic [5:0]  out_victim_entry
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_victim_found) &&
      $stable(out_victim_table) && $stable(out_victim_entry))
    else $error("result payload changed while stalled");

  // a miss reports zero table and entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_victim_found |-> out_victim_table == 1'b0 &&
      out_victim_entry == 6'd0)
    else $error("miss with nonzero victim fields");

  // a find transfer makes the block busy for its scan
  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_FIND |=> !in_ready)
    else $error("input accepted right after find");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_page_victim_selector_unit lpvs_checker u_lpvs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_victim_found(out_victim_found),
  .out_victim_table(out_victim_table),
  .out_victim_entry(out_victim_entry)
);

`default_nettype wire

// ----- tb/tb_lru_page_victim_selector_unit.sv -----
`timescale 1ns / 1ps

module tb_lru_page_victim_selector_unit;
  import lpvs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_CMDS = 900;
  localparam int DRAIN_EVERY = 150;

  typedef struct {
    bit                hold;   // pause marker: wait for all results before going on
    logic [1:0]        cmd;
    logic              tsel;
    logic [5:0]        idx;
    logic              vflag;
    logic [TIME_W-1:0] stamp;
    logic              pflag;
  } page_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_WRITE;
  logic        in_table_sel = 1'b0;
  logic [5:0]  in_entry_index = '0;
  logic        in_valid_flag = 1'b0;
  logic [30:0] in_last_use_time = '0;
  logic        in_present_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_victim_found;
  logic        out_victim_table;
  logic [5:0]  out_victim_entry;

  always #1 clk = ~clk;

  lru_page_victim_selector_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_table_sel     (in_table_sel),
    .in_entry_index   (in_entry_index),
    .in_valid_flag    (in_valid_flag),
    .in_last_use_time (in_last_use_time),
    .in_present_flag  (in_present_flag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_victim_found (out_victim_found),
    .out_victim_table (out_victim_table),
    .out_victim_entry (out_victim_entry)
  );

  // shadow copy of the page tables
  bit                pt_valid   [NUM_TABLES][PAGES_PER_TABLE];
  bit [TIME_W-1:0]   pt_time    [NUM_TABLES][PAGES_PER_TABLE];
  bit                pt_present [NUM_TABLES];

  page_cmd_t   pending_cmds[$];
  scan_res_t   victim_q[$];
  int          total_cmds = 0;
  int          cmds_sent = 0;
  int          finds_issued = 0;
  int          results_seen = 0;
  int          victims_seen = 0;
  int          mismatches = 0;
  int unsigned use_clock = 0;

  function automatic scan_res_t pick_lru_victim();
    scan_res_t         res;
    logic [TIME_W-1:0] oldest;
    res = '0;
    oldest = TIME_MAX;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (pt_present[t]) begin
        for (int e = 0; e < PAGES_PER_TABLE; e++) begin
          // strict compare: first in scan order wins a tie, all-ones never wins
          if (pt_valid[t][e] && pt_time[t][e] < oldest) begin
            oldest = pt_time[t][e];
            res.found = 1'b1;
            res.tab = t[TAB_W-1:0];
            res.ent = e[ENT_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void track_command(page_cmd_t c);
    case (c.cmd)
      CMD_WRITE: begin
        pt_valid[c.tsel][c.idx] = c.vflag;
        pt_time[c.tsel][c.idx] = c.stamp;
      end
      CMD_PRESENT: pt_present[c.tsel] = c.pflag;
      CMD_FIND: victim_q.push_back(pick_lru_victim());
      default: ;
    endcase
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // half of the stamps come from an advancing use clock, as a real LRU tracker would see
  function automatic logic [TIME_W-1:0] pick_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      use_clock = use_clock + $urandom_range(0, 3);
      return use_clock[TIME_W-1:0];
    end
    if (r < 65) return TIME_W'($urandom_range(0, 15));
    if (r < 75) return TIME_W'($urandom_range(0, 1023));
    if (r < 85) return TIME_MAX;
    if (r < 90) return TIME_MAX - 31'd1;
    return TIME_W'($urandom);
  endfunction

  task automatic queue_cmd(logic [1:0] cmd, logic tsel, logic [5:0] idx, logic vflag,
                           logic [TIME_W-1:0] stamp, logic pflag);
    page_cmd_t c;
    c.hold = 1'b0;
    c.cmd = cmd;
    c.tsel = tsel;
    c.idx = idx;
    c.vflag = vflag;
    c.stamp = stamp;
    c.pflag = pflag;
    pending_cmds.push_back(c);
    total_cmds++;
  endtask

  task automatic queue_hold();
    page_cmd_t c;
    c = '{default: '0};
    c.hold = 1'b1;
    pending_cmds.push_back(c);
  endtask

  // sender
  page_cmd_t cur_cmd;
  int        send_gap = 0;
  int        send_calm = 0;

  always @(posedge clk) begin
    page_cmd_t nxt;
    bit        fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        track_command(cur_cmd);
        cmds_sent <= cmds_sent + 1;
        if (cur_cmd.cmd == CMD_FIND) finds_issued <= finds_issued + 1;
      end
      if (!in_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_cmds[0].hold) begin
          in_valid <= 1'b0;
          if (!fire && finds_issued == results_seen) nxt = pending_cmds.pop_front();
        end else begin
          nxt = pending_cmds.pop_front();
          cur_cmd = nxt;
          in_cmd <= nxt.cmd;
          in_table_sel <= nxt.tsel;
          in_entry_index <= nxt.idx;
          in_valid_flag <= nxt.vflag;
          in_last_use_time <= nxt.stamp;
          in_present_flag <= nxt.pflag;
          in_valid <= 1'b1;
          if (send_calm > 0) send_calm--;
          else if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(30, 150);
          send_gap = pick_gap(send_calm != 0);
        end
      end
    end
  end

  // receiver and result check
  int recv_stall = 0;
  int recv_calm = 0;

  always @(posedge clk) begin
    scan_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_victim_found === 1'b1) victims_seen <= victims_seen + 1;
        if (victim_q.size() == 0) begin
          $error("result transfer with no find outstanding");
          mismatches++;
        end else begin
          want = victim_q.pop_front();
          if (out_victim_found !== want.found) begin
            $error("victim_found: expected %0d, actual %0d", want.found, out_victim_found);
            mismatches++;
          end
          if (out_victim_table !== want.tab) begin
            $error("victim_table: expected %0d, actual %0d", want.tab, out_victim_table);
            mismatches++;
          end
          if (out_victim_entry !== want.ent) begin
            $error("victim_entry: expected %0d, actual %0d", want.ent, out_victim_entry);
            mismatches++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(30, 150);
        recv_stall = pick_gap(recv_calm != 0);
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a transfer", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    page_cmd_t c;
    int        r;

    // directed: empty tables, absent tables, ties, max stamp, invalidation
    queue_cmd(CMD_FIND, 1'b1, 6'h2A, 1'b1, TIME_MAX, 1'b1);
    queue_cmd(CMD_WRITE, 1'b0, 6'd5, 1'b1, 31'd100, 1'b0);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_PRESENT, 1'b0, 6'h15, 1'b0, 31'h1234, 1'b1);
    queue_cmd(CMD_FIND, 1'b0, 6'd63, 1'b1, 31'd7, 1'b0);
    queue_cmd(CMD_WRITE, 1'b1, 6'd0, 1'b1, 31'd100, 1'b1);
    queue_cmd(CMD_PRESENT, 1'b1, 6'd0, 1'b1, 31'd0, 1'b1);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_WRITE, 1'b0, 6'd63, 1'b1, 31'd0, 1'b0);
    queue_cmd(CMD_FIND, 1'b1, 6'd1, 1'b0, 31'd1, 1'b1);
    queue_cmd(CMD_WRITE, 1'b0, 6'd63, 1'b1, TIME_MAX, 1'b1);
    queue_cmd(CMD_WRITE, 1'b0, 6'd5, 1'b1, TIME_MAX, 1'b0);
    queue_cmd(CMD_WRITE, 1'b1, 6'd0, 1'b1, TIME_MAX, 1'b0);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_WRITE, 1'b1, 6'd63, 1'b1, TIME_MAX - 31'd1, 1'b0);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_UNUSED, 1'b1, 6'd63, 1'b1, TIME_MAX, 1'b1);
    queue_cmd(CMD_WRITE, 1'b1, 6'd63, 1'b0, 31'd0, 1'b1);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_WRITE, 1'b1, 6'd31, 1'b1, 31'h2AAA_AAAA, 1'b0);
    queue_cmd(CMD_WRITE, 1'b1, 6'd32, 1'b1, 31'h5555_5555, 1'b1);
    queue_cmd(CMD_PRESENT, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_PRESENT, 1'b1, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_cmd(CMD_FIND, 1'b0, 6'd0, 1'b0, 31'd0, 1'b0);
    queue_hold();

    // random: both tables usually present, stamps from an advancing use clock
    queue_cmd(CMD_PRESENT, 1'b0, 6'($urandom), 1'($urandom), TIME_W'($urandom), 1'b1);
    queue_cmd(CMD_PRESENT, 1'b1, 6'($urandom), 1'($urandom), TIME_W'($urandom), 1'b1);
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        queue_hold();
        use_clock = ($urandom_range(0, 3) == 0) ? 32'(TIME_MAX - 31'd200)
                                                : $urandom_range(0, 5000);
      end
      c.hold = 1'b0;
      c.tsel = 1'($urandom);
      c.idx = 6'($urandom);
      c.vflag = 1'($urandom);
      c.stamp = TIME_W'($urandom);
      c.pflag = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 58) begin
        c.cmd = CMD_WRITE;
        c.vflag = ($urandom_range(0, 3) != 0);
        c.stamp = pick_stamp();
      end else if (r < 66) begin
        c.cmd = CMD_PRESENT;
        c.pflag = ($urandom_range(0, 4) != 0);
      end else if (r < 96) begin
        c.cmd = CMD_FIND;
      end else begin
        c.cmd = CMD_UNUSED;
      end
      pending_cmds.push_back(c);
      total_cmds++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_sent != total_cmds) @(posedge clk);
    while (finds_issued != results_seen) @(posedge clk);
    repeat (200) @(posedge clk);
    if (victim_q.size() != 0) begin
      $error("%0d find results never arrived", victim_q.size());
      mismatches += victim_q.size();
    end

    $display("Run: %0d commands transferred, %0d finds scanned, %0d of them chose a victim",
             cmds_sent, results_seen, victims_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
